[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the pause monitor
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, idle while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/prwm_pkg.sv]
// ---------------------------------------------------------------------------
// prwm_pkg
// shared types, codes and helpers of the pause ratio window monitor
// ---------------------------------------------------------------------------
package prwm_pkg;

    localparam int OP_W   = 3;
    localparam int TS_W   = 63;
    localparam int IDX_W  = 4;
    localparam int DUR_W  = 48;
    localparam int PM_W   = 10;
    localparam int US_W   = 39;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 3;

    // request op codes on the input channel
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd0;
    localparam logic [OP_W-1:0] OP_START    = 3'd1;
    localparam logic [OP_W-1:0] OP_END      = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR_CNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd4;

    // classified work kinds handed to the back end
    localparam logic [KIND_W-1:0] K_NOP      = 3'd0;
    localparam logic [KIND_W-1:0] K_QUERY    = 3'd1;
    localparam logic [KIND_W-1:0] K_START    = 3'd2;
    localparam logic [KIND_W-1:0] K_END      = 3'd3;
    localparam logic [KIND_W-1:0] K_CLR_CNT  = 3'd4;
    localparam logic [KIND_W-1:0] K_ACTIVATE = 3'd5;

    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    // serial divider geometry
    localparam int DIV_NW   = 64;
    localparam int DIV_DW   = 66;
    localparam int STEP_W   = 6;
    localparam int PM_STEPS = PM_W;

    // ns to us: (ns >> 3) * ceil(2^52 / 125) >> 52, exact for any 48-bit
    // duration, built from four 24 x 24 partial products
    localparam int                    US_MUL_W = 24;
    localparam int                    US_ACC_W = 96;
    localparam int                    US_SHIFT = 52;
    localparam logic [2*US_MUL_W-1:0] US_RECIP = 48'd36028797018964;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TS_W-1:0]   now;
        logic [IDX_W-1:0]  read_index;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den_sh;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [US_W-1:0] quo;
    } div_rsp_t;

    // later minus earlier, clamped to zero and to the duration ceiling
    function automatic logic [DUR_W-1:0] span(input logic [TS_W-1:0] later,
                                              input logic [TS_W-1:0] earlier);
        logic [TS_W-1:0] d;
        begin
            d = later - earlier;
            if (later <= earlier)
                return '0;
            else if (d > TS_W'(DUR_MAX))
                return DUR_MAX;
            else
                return d[DUR_W-1:0];
        end
    endfunction

endpackage

[hdl/prwm_ram.sv]
// ---------------------------------------------------------------------------
// prwm_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module prwm_ram #(
    parameter int WIDTH  = 63,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/prwm_front.sv]
// ---------------------------------------------------------------------------
// prwm_front
// input acceptance, config register and request classification
// ---------------------------------------------------------------------------
module prwm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [prwm_pkg::OP_W-1:0]     op,
    input  logic [prwm_pkg::TS_W-1:0]     timestamp_ns,
    input  logic [prwm_pkg::IDX_W-1:0]    read_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          events_enabled,
    input  logic                          q_full,
    output logic                          q_push,
    output prwm_pkg::cmd_t                q_cmd
);

    import prwm_pkg::*;

    logic              events_enabled_reg;
    logic              events_enabled_next;
    logic [KIND_W-1:0] kind;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        events_enabled_next = events_enabled_reg;
        if (cfg_valid && cfg_ready)
            events_enabled_next = events_enabled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            events_enabled_reg <= 1'b0;
        else
            events_enabled_reg <= events_enabled_next;
    end

    // start and end turn into no-ops while events are off
    always_comb
    begin
        unique case (op)
            OP_QUERY:    kind = K_QUERY;
            OP_START:    kind = events_enabled_reg ? K_START : K_NOP;
            OP_END:      kind = events_enabled_reg ? K_END : K_NOP;
            OP_CLR_CNT:  kind = K_CLR_CNT;
            OP_ACTIVATE: kind = K_ACTIVATE;
            default:     kind = K_NOP;
        endcase
    end

    assign in_stall          = q_full;
    assign q_push            = in_valid && !q_full;
    assign q_cmd.kind        = kind;
    assign q_cmd.now         = timestamp_ns;
    assign q_cmd.read_index  = read_index;

endmodule

[hdl/prwm_queue.sv]
// ---------------------------------------------------------------------------
// prwm_queue
// two-entry request queue between front and back end
// ---------------------------------------------------------------------------
module prwm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  prwm_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output prwm_pkg::cmd_t head,
    output logic           not_empty
);

    import prwm_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    cmd_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = count_reg == CNT_QW'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/prwm_div.sv]
// ---------------------------------------------------------------------------
// prwm_div
// restoring divider, one quotient bit per cycle, pre-shifted divisor
// ---------------------------------------------------------------------------
module prwm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  prwm_pkg::div_req_t req,
    output prwm_pkg::div_rsp_t rsp
);

    import prwm_pkg::*;

    logic [DIV_NW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] d_reg, d_next;
    logic [US_W-1:0]   q_reg, q_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = {{(DIV_DW - DIV_NW){1'b0}}, rem_reg} >= d_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.num;
            d_next    = req.den_sh;
            q_next    = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // divisor at or below the remainder means its top bits are clear
            if (ge)
                rem_next = rem_reg - d_reg[DIV_NW-1:0];
            q_next   = {q_reg[US_W-2:0], ge};
            d_next   = d_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

[hdl/prwm_back.sv]
// ---------------------------------------------------------------------------
// prwm_back
// executes requests: windows, rings, counters, query math, result register
// ---------------------------------------------------------------------------
module prwm_back #(
    parameter int WINDOW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  prwm_pkg::cmd_t                q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [prwm_pkg::PM_W-1:0]     pause_permille,
    output logic [prwm_pkg::US_W-1:0]     last_pause_us,
    output logic [prwm_pkg::CNT_W-1:0]    epoch_count,
    output logic [prwm_pkg::TS_W-1:0]     start_time_entry,
    output logic [prwm_pkg::TS_W-1:0]     end_time_entry
);

    import prwm_pkg::*;

    localparam int AW   = $clog2(WINDOW);
    localparam int IW   = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
    localparam int SW   = DUR_W + $clog2(WINDOW);
    localparam int RTW  = SW + 1;
    localparam int DENW = SW + 2;
    localparam int NUMW = SW + 10;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SPAN   = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_DEN    = 3'd3;
    localparam logic [2:0] S_DIV_PM = 3'd4;
    localparam logic [2:0] S_US_MUL = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [RTW-1:0]    run_total_reg, run_total_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic              zero_reg, zero_next;
    logic [PM_W-1:0]   pm_reg, pm_next;
    logic [US_W-1:0]   us_reg, us_next;
    logic [US_ACC_W-1:0] us_acc_reg, us_acc_next;
    logic [1:0]        mul_step_reg, mul_step_next;

    logic [DUR_W-1:0]  run_win_reg   [WINDOW];
    logic [DUR_W-1:0]  pause_win_reg [WINDOW];
    logic [SW-1:0]     sum_run_reg, sum_run_next;
    logic [SW-1:0]     sum_pause_reg, sum_pause_next;
    logic [AW-1:0]     start_ptr_reg, start_ptr_next;
    logic [AW-1:0]     end_ptr_reg, end_ptr_next;
    logic [WINDOW-1:0] start_vld_reg, start_vld_next;
    logic [WINDOW-1:0] end_vld_reg, end_vld_next;
    logic [TS_W-1:0]   last_start_reg, last_start_next;
    logic [TS_W-1:0]   last_end_reg, last_end_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [PM_W-1:0]   out_pm_reg, out_pm_next;
    logic [US_W-1:0]   out_us_reg, out_us_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [TS_W-1:0]   out_start_reg, out_start_next;
    logic [TS_W-1:0]   out_end_reg, out_end_next;

    logic              push_run, push_pause, clear_all;
    logic              start_we, end_we, rd_en;
    logic [TS_W-1:0]   start_rdata, end_rdata;
    logic [IW-1:0]     idx_ext;
    logic              idx_ok;
    logic [AW-1:0]     rd_addr;
    logic [NUMW-1:0]   p_ext;
    logic [DENW-1:0]   den;
    logic              is_query;
    logic              slot_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [2*US_MUL_W-1:0] us_y;
    logic [US_MUL_W-1:0]   mul_a, mul_b;
    logic [6:0]            mul_sh;
    logic [2*US_MUL_W-1:0] mul_p;
    logic [US_ACC_W-1:0]   mul_term;
    logic [US_ACC_W-1:0]   us_acc_sum;

    assign idx_ext  = IW'(cmd_reg.read_index);
    assign idx_ok   = idx_ext < IW'(WINDOW);
    assign rd_addr  = idx_ext[AW-1:0];
    assign p_ext    = NUMW'(sum_pause_reg);
    assign den      = DENW'(sum_pause_reg) + DENW'(run_total_reg);
    assign is_query = cmd_reg.kind == K_QUERY;
    assign slot_free = !out_valid_reg || !out_stall;

    // newest pause over 8, then one partial product per cycle
    assign us_y = {3'b000, pause_win_reg[WINDOW-1][DUR_W-1:3]};

    always_comb
    begin
        unique case (mul_step_reg)
            2'd0:
            begin
                mul_a  = us_y[US_MUL_W-1:0];
                mul_b  = US_RECIP[US_MUL_W-1:0];
                mul_sh = 7'd0;
            end
            2'd1:
            begin
                mul_a  = us_y[US_MUL_W-1:0];
                mul_b  = US_RECIP[2*US_MUL_W-1:US_MUL_W];
                mul_sh = 7'(US_MUL_W);
            end
            2'd2:
            begin
                mul_a  = us_y[2*US_MUL_W-1:US_MUL_W];
                mul_b  = US_RECIP[US_MUL_W-1:0];
                mul_sh = 7'(US_MUL_W);
            end
            2'd3:
            begin
                mul_a  = us_y[2*US_MUL_W-1:US_MUL_W];
                mul_b  = US_RECIP[2*US_MUL_W-1:US_MUL_W];
                mul_sh = 7'(2 * US_MUL_W);
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign mul_term   = US_ACC_W'(mul_p) << mul_sh;
    assign us_acc_sum = us_acc_reg + mul_term;

    prwm_ram #(.WIDTH(TS_W), .DEPTH(WINDOW)) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (start_ptr_reg),
        .wdata (cmd_reg.now),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (start_rdata)
    );

    prwm_ram #(.WIDTH(TS_W), .DEPTH(WINDOW)) u_end_ram (
        .clk   (clk),
        .we    (end_we),
        .waddr (end_ptr_reg),
        .wdata (cmd_reg.now),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (end_rdata)
    );

    prwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        dur_next        = dur_reg;
        run_total_next  = run_total_reg;
        num_next        = num_reg;
        zero_next       = zero_reg;
        pm_next         = pm_reg;
        us_next         = us_reg;
        us_acc_next     = us_acc_reg;
        mul_step_next   = mul_step_reg;
        sum_run_next    = sum_run_reg;
        sum_pause_next  = sum_pause_reg;
        start_ptr_next  = start_ptr_reg;
        end_ptr_next    = end_ptr_reg;
        start_vld_next  = start_vld_reg;
        end_vld_next    = end_vld_reg;
        last_start_next = last_start_reg;
        last_end_next   = last_end_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_pm_next     = out_pm_reg;
        out_us_next     = out_us_reg;
        out_cnt_next    = out_cnt_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        push_run        = 1'b0;
        push_pause      = 1'b0;
        clear_all       = 1'b0;
        start_we        = 1'b0;
        end_we          = 1'b0;
        rd_en           = 1'b0;
        q_pop           = 1'b0;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                // pause length for an end, run length for the rest
                if (cmd_reg.kind == K_END)
                    dur_next = span(cmd_reg.now, last_start_reg);
                else
                    dur_next = span(cmd_reg.now, last_end_reg);
                rd_en      = is_query;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_DONE;
                case (cmd_reg.kind)
                    K_START:
                    begin
                        push_run        = 1'b1;
                        sum_run_next    = sum_run_reg + SW'(dur_reg) - SW'(run_win_reg[0]);
                        start_we        = 1'b1;
                        start_vld_next[start_ptr_reg] = 1'b1;
                        start_ptr_next  = (start_ptr_reg == AW'(WINDOW - 1)) ? '0
                                        : start_ptr_reg + 1'b1;
                        last_start_next = cmd_reg.now;
                    end
                    K_END:
                    begin
                        push_pause     = 1'b1;
                        sum_pause_next = sum_pause_reg + SW'(dur_reg) - SW'(pause_win_reg[0]);
                        end_we         = 1'b1;
                        end_vld_next[end_ptr_reg] = 1'b1;
                        end_ptr_next   = (end_ptr_reg == AW'(WINDOW - 1)) ? '0
                                       : end_ptr_reg + 1'b1;
                        last_end_next  = cmd_reg.now;
                        cnt_next       = cnt_reg + 1'b1;
                    end
                    K_CLR_CNT:
                    begin
                        cnt_next = '0;
                    end
                    K_ACTIVATE:
                    begin
                        clear_all      = 1'b1;
                        sum_run_next   = '0;
                        sum_pause_next = '0;
                        start_vld_next = '0;
                        end_vld_next   = '0;
                        cnt_next       = '0;
                        last_end_next  = cmd_reg.now;
                    end
                    K_QUERY:
                    begin
                        run_total_next = RTW'(sum_run_reg) + RTW'(dur_reg);
                        // times 1000 as 1024 - 16 - 8
                        num_next   = (p_ext << 10) - (p_ext << 4) - (p_ext << 3);
                        state_next = S_DEN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DEN:
            begin
                zero_next      = run_total_reg == '0;
                div_req.start  = 1'b1;
                div_req.num    = DIV_NW'(num_reg);
                div_req.den_sh = DIV_DW'(den) << (PM_STEPS - 1);
                div_req.steps  = STEP_W'(PM_STEPS);
                state_next     = S_DIV_PM;
            end
            S_DIV_PM:
            begin
                if (div_rsp.done)
                begin
                    pm_next       = zero_reg ? '0 : div_rsp.quo[PM_W-1:0];
                    us_acc_next   = '0;
                    mul_step_next = '0;
                    state_next    = S_US_MUL;
                end
            end
            S_US_MUL:
            begin
                us_acc_next   = us_acc_sum;
                mul_step_next = mul_step_reg + 1'b1;
                if (mul_step_reg == 2'd3)
                begin
                    us_next    = us_acc_sum[US_SHIFT +: US_W];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_pm_next    = is_query ? pm_reg : '0;
                    out_us_next    = is_query ? us_reg : '0;
                    out_cnt_next   = is_query ? cnt_reg : '0;
                    out_start_next = (is_query && idx_ok && start_vld_reg[rd_addr])
                                   ? start_rdata : '0;
                    out_end_next   = (is_query && idx_ok && end_vld_reg[rd_addr])
                                   ? end_rdata : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // duration windows, oldest at index zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                run_win_reg[i]   <= '0;
                pause_win_reg[i] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                run_win_reg[i]   <= '0;
                pause_win_reg[i] <= '0;
            end
        end
        else
        begin
            if (push_run)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                    run_win_reg[i] <= run_win_reg[i+1];
                run_win_reg[WINDOW-1] <= dur_reg;
            end
            if (push_pause)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                    pause_win_reg[i] <= pause_win_reg[i+1];
                pause_win_reg[WINDOW-1] <= dur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        dur_reg        <= dur_next;
        run_total_reg  <= run_total_next;
        num_reg        <= num_next;
        zero_reg       <= zero_next;
        pm_reg         <= pm_next;
        us_reg         <= us_next;
        us_acc_reg     <= us_acc_next;
        out_pm_reg     <= out_pm_next;
        out_us_reg     <= out_us_next;
        out_cnt_reg    <= out_cnt_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mul_step_reg   <= '0;
            sum_run_reg    <= '0;
            sum_pause_reg  <= '0;
            start_ptr_reg  <= '0;
            end_ptr_reg    <= '0;
            start_vld_reg  <= '0;
            end_vld_reg    <= '0;
            last_start_reg <= '0;
            last_end_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mul_step_reg   <= mul_step_next;
            sum_run_reg    <= sum_run_next;
            sum_pause_reg  <= sum_pause_next;
            start_ptr_reg  <= start_ptr_next;
            end_ptr_reg    <= end_ptr_next;
            start_vld_reg  <= start_vld_next;
            end_vld_reg    <= end_vld_next;
            last_start_reg <= last_start_next;
            last_end_reg   <= last_end_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pause_permille   = out_pm_reg;
    assign last_pause_us    = out_us_reg;
    assign epoch_count      = out_cnt_reg;
    assign start_time_entry = out_start_reg;
    assign end_time_entry   = out_end_reg;

endmodule

[hdl/pause_ratio_window_monitor.sv]
// path: a request is popped in idle, passes span and apply, and its result is
//   registered from done once the output slot is free; a query also passes den, the
//   one-bit-per-cycle permille divider (10 steps) and a serial multiply for the us value
// intake: back end takes a new request only once the last one has left done,
//   and two more requests may wait in the queue
// reset: asynchronous, clears windows, ring valid bits, pointers, counter and config
// ---------------------------------------------------------------------------
// pause_ratio_window_monitor
// pause duty-cycle monitor over sliding windows of run and pause durations
// ---------------------------------------------------------------------------
module pause_ratio_window_monitor #(
    parameter int WINDOW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [prwm_pkg::OP_W-1:0]     op,
    input  logic [prwm_pkg::TS_W-1:0]     timestamp_ns,
    input  logic [prwm_pkg::IDX_W-1:0]    read_index,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [prwm_pkg::PM_W-1:0]     pause_permille,
    output logic [prwm_pkg::US_W-1:0]     last_pause_us,
    output logic [prwm_pkg::CNT_W-1:0]    epoch_count,
    output logic [prwm_pkg::TS_W-1:0]     start_time_entry,
    output logic [prwm_pkg::TS_W-1:0]     end_time_entry,
    // config write channel, single register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          events_enabled
);

    import prwm_pkg::*;

    // front to queue
    logic q_push;
    cmd_t q_cmd;
    logic q_full;

    // queue to back end
    cmd_t q_head;
    logic q_not_empty;
    logic q_pop;

    // front end: takes a request whenever the queue has room, turns the op
    // into a work kind and turns start/end into no-ops when events are disabled
    prwm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .timestamp_ns   (timestamp_ns),
        .read_index     (read_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .events_enabled (events_enabled),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_cmd)
    );

    // short queue decouples request intake from the long query path
    prwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // back end: keeps running sums beside the shift windows so a query needs
    // no pass over the window, timestamp rings live in two small rams with
    // per-entry valid bits, and the result sits in an output register
    prwm_back #(.WINDOW(WINDOW)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pause_permille   (pause_permille),
        .last_pause_us    (last_pause_us),
        .epoch_count      (epoch_count),
        .start_time_entry (start_time_entry),
        .end_time_entry   (end_time_entry)
    );

endmodule

[hdl/prwm_checker.sv]
// ---------------------------------------------------------------------------
// prwm_port_checks
// port-level checks of the pause monitor, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module prwm_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [prwm_pkg::PM_W-1:0]     pause_permille,
    input logic [prwm_pkg::US_W-1:0]     last_pause_us,
    input logic [prwm_pkg::CNT_W-1:0]    epoch_count
);

    import prwm_pkg::*;

    localparam logic [US_W-1:0] US_MAX = 39'd281474976710;

    // a stalled result stays valid and its epoch count holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(epoch_count))

    // share never above one thousand
    `ASSERT_IMPLY(a_pm_range, clk, rst_n, out_valid, pause_permille <= PM_W'(1000))

    // saturated pause in microseconds stays at or below the ceiling
    `ASSERT_IMPLY(a_us_range, clk, rst_n, out_valid, last_pause_us <= US_MAX)

endmodule

bind pause_ratio_window_monitor prwm_port_checks u_prwm_checker (.*);
